>>> hw/rtl/mla_pkg.sv
package mla_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_ABSENT   = 3'd2,
		ST_FULL     = 3'd3,
		ST_DISABLED = 3'd4
	} status_t;

	// per-cell write control from the sequencer
	typedef struct packed {
		logic load;   // take the broadcast key (append)
		logic shift;  // take the upper neighbor's key (compaction)
	} cell_ctl_t;

endpackage

>>> hw/rtl/mla_cell.sv
// One list slot: stores a key, registers a match against the broadcast key,
// and can take its upper neighbor's key when the list closes a gap.
module mla_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmp_en,
	input  mla_pkg::key_t       cmp_key,
	input  logic                valid,
	input  mla_pkg::cell_ctl_t  ctl,
	input  mla_pkg::key_t       load_key,
	input  mla_pkg::key_t       next_key,
	output mla_pkg::key_t       key,
	output logic                hit
);

	mla_pkg::key_t key_q;
	logic          hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmp_en) begin
			hit_q <= valid && (key_q == cmp_key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= load_key;
		end else if (ctl.shift) begin
			key_q <= next_key;
		end
	end

	assign key = key_q;
	assign hit = hit_q;

endmodule

>>> hw/rtl/mla_encode.sv
// Match vector to index. Keys in the valid range are distinct, so at most
// one bit is set and an OR of the indices is enough.
module mla_encode (
	input  logic [mla_pkg::CAPACITY-1:0] hit,
	output logic                         any,
	output mla_pkg::idx_t                idx
);

	always_comb begin
		idx = '0;
		for (int i = 0; i < mla_pkg::CAPACITY; i++) begin
			if (hit[i]) begin
				idx = idx | mla_pkg::IDX_W'(i);
			end
		end
	end

	assign any = |hit;

endmodule

>>> hw/rtl/membership_list_add_remove.sv
// Channel   | Signals                                         | Dir | Handshake
// ----------+-------------------------------------------------+-----+---------------------
// op        | start, opcode[1:0], node_key[31:0], busy        | in  | start && !busy
// result    | done, status[2:0], found, position[5:0],        | out | done, one cycle,
//           | entry_count[6:0]                                |     | cannot be held off
// config    | cfg_we, cfg_wdata                               | in  | cfg_we
//
// A new item is accepted in the cycle the result strobe is shown, so the
// block takes no new item before it is through with the last one. The
// three steps are: all cells compare the key at the accept edge, the match
// vector is encoded to an index, then cells load/shift and the result is
// registered. The index must be settled before cells can decide whether
// they sit above the removed slot, which sets the length.
// Reset (arst_n low) empties the list and sets enable_q; key storage is
// not cleared, only slots below the count are ever compared.
// busy is high from acceptance until the result edge; results are never
// stalled.
module membership_list_add_remove (
	input  logic        clk,
	input  logic        arst_n,
	// op channel
	input  logic        start,
	input  logic [1:0]  opcode,
	input  logic [31:0] node_key,
	output logic        busy,
	// result channel
	output logic        done,
	output logic [2:0]  status,
	output logic        found,
	output logic [5:0]  position,
	output logic [6:0]  entry_count,
	// config
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam int CAP = mla_pkg::CAPACITY;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ENC,
		S_APP
	} state_t;

	state_t              state_q;
	logic                enable_q;
	mla_pkg::cnt_t       count_q;
	mla_pkg::op_t        op_q;
	mla_pkg::key_t       key_q;
	logic                found_q;
	mla_pkg::idx_t       idx_q;

	logic                done_q;
	mla_pkg::status_t    status_q;
	logic                found_out_q;
	mla_pkg::idx_t       pos_q;
	mla_pkg::cnt_t       cnt_out_q;

	logic                accept;
	mla_pkg::key_t       in_key;
	logic [CAP-1:0]      hit;
	logic [CAP-1:0]      valid;
	mla_pkg::key_t       cell_key [CAP];
	mla_pkg::cell_ctl_t  ctl [CAP];
	logic                enc_any;
	mla_pkg::idx_t       enc_idx;

	logic                full;
	logic                add_go;
	logic                rem_go;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign in_key = mla_pkg::key_t'(node_key);

	assign full   = (count_q >= mla_pkg::CNT_W'(CAP));
	// a hit implies a non-empty list, hits are masked by the valid range
	assign add_go = (state_q == S_APP) && enable_q && (op_q == mla_pkg::OP_ADD)
			&& !found_q && !full;
	assign rem_go = (state_q == S_APP) && enable_q && (op_q == mla_pkg::OP_REMOVE)
			&& found_q;

	// ---- row of cells ----
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		assign valid[g]     = (mla_pkg::CNT_W'(g) < count_q);
		// append goes to the slot at the current count
		assign ctl[g].load  = add_go && (count_q == mla_pkg::CNT_W'(g));
		// every slot at or above the removed one takes its neighbor's key;
		// what lands beyond the new count is never compared
		assign ctl[g].shift = rem_go && (mla_pkg::IDX_W'(g) >= idx_q);

		mla_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmp_en   (accept),
			.cmp_key  (in_key),
			.valid    (valid[g]),
			.ctl      (ctl[g]),
			.load_key (key_q),
			.next_key (cell_key[(g + 1 < CAP) ? g + 1 : g]),
			.key      (cell_key[g]),
			.hit      (hit[g])
		);
	end

	mla_encode u_enc (
		.hit (hit),
		.any (enc_any),
		.idx (enc_idx)
	);

	// ---- config register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	// ---- captured item, not reset ----
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= mla_pkg::op_t'(opcode);
			key_q <= in_key;
		end
		if (state_q == S_ENC) begin
			found_q <= enc_any;
			idx_q   <= enc_idx;
		end
	end

	// ---- sequencer, count and registered result ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= mla_pkg::ST_OK;
			found_out_q <= 1'b0;
			pos_q       <= '0;
			cnt_out_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_ENC;
					end
				end
				S_ENC: begin
					state_q <= S_APP;
				end
				S_APP: begin
					state_q     <= S_IDLE;
					done_q      <= 1'b1;
					status_q    <= mla_pkg::ST_OK;
					found_out_q <= 1'b0;
					pos_q       <= '0;
					cnt_out_q   <= count_q;
					if (!enable_q) begin
						status_q <= mla_pkg::ST_DISABLED;
					end else begin
						unique case (op_q)
							mla_pkg::OP_QUERY: begin
								if (found_q) begin
									found_out_q <= 1'b1;
									pos_q       <= idx_q;
								end else begin
									status_q <= mla_pkg::ST_ABSENT;
								end
							end
							mla_pkg::OP_ADD: begin
								if (found_q) begin
									status_q    <= mla_pkg::ST_PRESENT;
									found_out_q <= 1'b1;
									pos_q       <= idx_q;
								end else if (full) begin
									status_q <= mla_pkg::ST_FULL;
								end else begin
									pos_q     <= mla_pkg::IDX_W'(count_q);
									count_q   <= count_q + mla_pkg::CNT_W'(1);
									cnt_out_q <= count_q + mla_pkg::CNT_W'(1);
								end
							end
							mla_pkg::OP_REMOVE: begin
								if (found_q) begin
									found_out_q <= 1'b1;
									pos_q       <= idx_q;
									count_q     <= count_q - mla_pkg::CNT_W'(1);
									cnt_out_q   <= count_q - mla_pkg::CNT_W'(1);
								end else begin
									status_q <= mla_pkg::ST_ABSENT;
								end
							end
							mla_pkg::OP_CLEAR: begin
								count_q   <= '0;
								cnt_out_q <= '0;
							end
							default: begin
								status_q <= mla_pkg::ST_OK;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = 3'(status_q);
	assign found       = found_out_q;
	assign position    = 6'(pos_q);
	assign entry_count = 7'(cnt_out_q);

endmodule

>>> hw/rtl/mla_checker.sv
module mla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic        found,
	input logic [5:0]  position,
	input logic [6:0]  entry_count
);

	// an accepted item keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// a result only appears once the block has finished its item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count <= 7'(mla_pkg::CAPACITY)))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == 3'(mla_pkg::ST_FULL)))
			|-> (entry_count == 7'(mla_pkg::CAPACITY) && !found))
		else $error("list full reported with room left");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == 3'(mla_pkg::ST_DISABLED)))
			|-> (!found && position == 6'd0))
		else $error("disabled result carries a hit");

endmodule

bind membership_list_add_remove mla_checker u_mla_checker (.*);

>>> dv/membership_checker.sv
`timescale 1ns / 100ps

module membership_checker
	import mla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  opcode,
	input  logic [31:0] node_key,
	input  logic        busy,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic        found,
	input  logic [5:0]  position,
	input  logic [6:0]  entry_count,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output int          fail_count,
	output int          awaiting,
	output int          results_checked,
	output int          full_rejects,
	output int          disabled_ops
);

	typedef struct packed {
		status_t status;
		logic    found;
		idx_t    position;
		cnt_t    entry_count;
	} list_result_t;

	// mirror of the list contents and the enable register
	key_t         stored_keys [CAPACITY];
	int           stored_count = 0;
	logic         list_on = 1'b1;
	list_result_t expected_results [$];
	int           mismatches = 0;
	int           checked = 0;
	int           n_full = 0;
	int           n_disabled = 0;

	// applies one operation to the mirror and returns the result it should give
	function automatic list_result_t apply_list_op(op_t op, key_t key);
		list_result_t r;
		int           hit;
		r.status   = ST_OK;
		r.found    = 1'b0;
		r.position = '0;
		hit        = -1;
		if (!list_on) begin
			r.status = ST_DISABLED;
		end else begin
			for (int i = 0; i < stored_count; i++)
				if (hit < 0 && stored_keys[i] == key)
					hit = i;
			case (op)
				OP_QUERY: begin
					if (hit >= 0) begin
						r.found    = 1'b1;
						r.position = idx_t'(hit);
					end else begin
						r.status = ST_ABSENT;
					end
				end
				OP_ADD: begin
					if (hit >= 0) begin
						r.status   = ST_PRESENT;
						r.found    = 1'b1;
						r.position = idx_t'(hit);
					end else if (stored_count >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						stored_keys[stored_count] = key;
						r.position                = idx_t'(stored_count);
						stored_count++;
					end
				end
				OP_REMOVE: begin
					if (hit >= 0) begin
						for (int j = hit; j < stored_count - 1; j++)
							stored_keys[j] = stored_keys[j + 1];
						stored_count--;
						r.found    = 1'b1;
						r.position = idx_t'(hit);
					end else begin
						r.status = ST_ABSENT;
					end
				end
				default: stored_count = 0;
			endcase
		end
		r.entry_count = cnt_t'(stored_count);
		return r;
	endfunction

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			stored_count = 0;
			list_on      = 1'b1;
			expected_results.delete();
		end else begin
			// retire the result first: an item accepted on this edge cannot be done yet
			if (done) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, status %0d count %0d",
						$time, status, entry_count);
				end else begin
					want = expected_results.pop_front();
					compare_field("status", want.status, status);
					compare_field("found", want.found, found);
					compare_field("position", want.position, position);
					compare_field("entry_count", want.entry_count, entry_count);
					checked++;
				end
			end
			if (cfg_we)
				list_on = cfg_wdata;
			if (start && !busy) begin
				want = apply_list_op(op_t'(opcode), node_key);
				if (want.status == ST_FULL)
					n_full++;
				if (want.status == ST_DISABLED)
					n_disabled++;
				expected_results.push_back(want);
			end
		end
		fail_count      <= mismatches;
		awaiting        <= expected_results.size();
		results_checked <= checked;
		full_rejects    <= n_full;
		disabled_ops    <= n_disabled;
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import mla_pkg::*;

	// cycles with no handshake at all before the run is declared hung;
	// the slowest legal stretch is a sender gap plus one item in flight
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 4;
	// more adds than slots, so a fill burst can run into a full list
	localparam int FILL_ADDS  = 70;
	localparam int MIXED_OPS  = 130;
	localparam int POOL_DEPTH = 128;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [1:0]  opcode      = OP_QUERY;
	logic [31:0] node_key    = '0;
	logic        cfg_we      = 1'b0;
	logic        cfg_wdata   = 1'b0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic        found;
	logic [5:0]  position;
	logic [6:0]  entry_count;

	int fail_count;
	int awaiting;
	int results_checked;
	int full_rejects;
	int disabled_ops;

	// keys handed out so far; reused so that queries, duplicate adds and
	// removes actually hit entries in the list
	key_t key_pool [POOL_DEPTH];
	int   pool_size   = 0;
	int   pool_next   = 0;
	int   idle_cycles = 0;
	bit   allow_idle  = 1'b1;
	int   items_sent  = 0;

	always #5 clk = ~clk;

	membership_list_add_remove dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.node_key    (node_key),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.found       (found),
		.position    (position),
		.entry_count (entry_count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	membership_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.opcode          (opcode),
		.node_key        (node_key),
		.busy            (busy),
		.done            (done),
		.status          (status),
		.found           (found),
		.position        (position),
		.entry_count     (entry_count),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.awaiting        (awaiting),
		.results_checked (results_checked),
		.full_rejects    (full_rejects),
		.disabled_ops    (disabled_ops)
	);

	// watchdog: any accepted item, result or register write resets the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Present one item and hold it until accepted. start is left high on
	// return; the caller either issues the next item in the same step or
	// lowers start through a gap or a drain.
	task automatic issue(op_t op, key_t key);
		opcode   <= op;
		node_key <= key;
		start    <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// random sender gap, so gaps land on every step of an item
	task automatic maybe_gap();
		if (allow_idle && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Stop sending until every outstanding result is back, then give the
	// block its latency to settle. The first edge lets the last accept show up
	// in the checker's outstanding count.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaiting != 0);
		repeat (4) @(posedge clk);
	endtask

	// only ever called with the list idle
	task automatic set_enable(logic value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// new key, biased toward all-zero, all-one and one-hot patterns
	function automatic key_t fresh_key();
		key_t k;
		case ($urandom_range(0, 19))
			0:       k = '0;
			1:       k = '1;
			2:       k = key_t'(1) << $urandom_range(0, KEY_BITS - 1);
			default: k = $urandom();
		endcase
		key_pool[pool_next] = k;
		pool_next           = (pool_next + 1) % POOL_DEPTH;
		if (pool_size < POOL_DEPTH)
			pool_size++;
		return k;
	endfunction

	// mostly a key seen before, sometimes a new one
	function automatic key_t pick_key();
		if (pool_size != 0 && $urandom_range(0, 99) < 75)
			return key_pool[$urandom_range(0, pool_size - 1)];
		return fresh_key();
	endfunction

	initial begin
		int r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, duplicate add, removal at both ends, clear
		issue(OP_QUERY,  32'h0000_0000);   // miss on the empty list
		issue(OP_REMOVE, 32'h0000_0000);   // remove from the empty list
		issue(OP_ADD,    32'h0000_0000);
		issue(OP_ADD,    32'hFFFF_FFFF);
		issue(OP_ADD,    32'h0000_0000);   // already present
		issue(OP_QUERY,  32'hFFFF_FFFF);
		issue(OP_ADD,    32'hA5A5_A5A5);
		issue(OP_ADD,    32'h5A5A_5A5A);
		issue(OP_REMOVE, 32'h0000_0000);   // first entry, everything shifts down
		issue(OP_QUERY,  32'h5A5A_5A5A);   // now one slot lower
		issue(OP_REMOVE, 32'h5A5A_5A5A);   // last entry, nothing to shift
		issue(OP_REMOVE, 32'h1234_5678);   // absent key
		issue(OP_CLEAR,  32'h0000_0000);
		issue(OP_QUERY,  32'hFFFF_FFFF);   // gone after the clear
		issue(OP_CLEAR,  32'hFFFF_FFFF);   // clear an already empty list

		// disabled: every op reports disabled and leaves the list alone
		set_enable(1'b0);
		issue(OP_ADD,    32'h0000_0001);
		issue(OP_REMOVE, 32'hFFFF_FFFF);
		issue(OP_QUERY,  32'h0000_0000);
		issue(OP_CLEAR,  32'h0000_0000);
		set_enable(1'b1);
		issue(OP_ADD,    32'h8000_0000);
		issue(OP_QUERY,  32'h8000_0000);
		drain();

		// random phases: a fill burst that overruns capacity, then churn.
		// The last phase runs with no sender gaps.
		for (int phase = 0; phase < PHASES; phase++) begin
			allow_idle = (phase != PHASES - 1);
			for (int i = 0; i < FILL_ADDS; i++) begin
				maybe_gap();
				issue(OP_ADD, fresh_key());
			end
			for (int i = 0; i < MIXED_OPS; i++) begin
				maybe_gap();
				r = $urandom_range(0, 99);
				if (r < 35)
					issue(OP_ADD, pick_key());
				else if (r < 60)
					issue(OP_QUERY, pick_key());
				else if (r < 97)
					issue(OP_REMOVE, pick_key());
				else
					issue(OP_CLEAR, pick_key());
				// occasional full stop mid-phase
				if (allow_idle && $urandom_range(0, 199) == 0)
					drain();
			end
			// a disabled stretch with the list partly filled
			if (phase == 1) begin
				set_enable(1'b0);
				for (int i = 0; i < 30; i++) begin
					maybe_gap();
					issue(op_t'($urandom_range(0, 3)), pick_key());
				end
				set_enable(1'b1);
			end
			drain();
		end

		$display("Run covered %0d items, %0d results checked: %0d adds refused on a full list,",
			items_sent, results_checked, full_rejects);
		$display("%0d ops while disabled, across fill and churn phases with the enable toggled",
			disabled_ops);
		if (fail_count == 0 && awaiting == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, awaiting);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/mla_pkg.sv
hw/rtl/mla_cell.sv
hw/rtl/mla_encode.sv
hw/rtl/membership_list_add_remove.sv
hw/rtl/mla_checker.sv
dv/membership_checker.sv
dv/tb.sv
